// ===== src/sc1a_pkg.sv =====
// shared types, codes and the key table for the set 1 scan code decoder
// no dependencies
`default_nettype none

package sc1a_pkg;

  localparam logic [7:0] PREFIX_CODE = 8'hE0;
  localparam logic [6:0] KEY_LCTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_LALT    = 7'h38;
  localparam logic [6:0] KEY_LIMIT   = 7'h3B;

  typedef logic [7:0] code_t;
  typedef logic [6:0] char_t;

  typedef struct packed {
    logic ext;
    logic shift;
    logic ctrl;
    logic alt;
  } kbd_state_t;

  typedef struct packed {
    logic  emit;
    char_t ch;
  } dec_result_t;

  // {unshifted, shifted}
  function automatic logic [13:0] key_entry(input logic [5:0] idx);
    logic [13:0] e;
    case (idx)
      6'h01: e = {7'h1B, 7'h1B};
      6'h02: e = {7'h31, 7'h21};
      6'h03: e = {7'h32, 7'h40};
      6'h04: e = {7'h33, 7'h23};
      6'h05: e = {7'h34, 7'h24};
      6'h06: e = {7'h35, 7'h25};
      6'h07: e = {7'h36, 7'h5E};
      6'h08: e = {7'h37, 7'h26};
      6'h09: e = {7'h38, 7'h2A};
      6'h0A: e = {7'h39, 7'h28};
      6'h0B: e = {7'h30, 7'h29};
      6'h0C: e = {7'h2D, 7'h5F};
      6'h0D: e = {7'h3D, 7'h2B};
      6'h0E: e = {7'h08, 7'h08};
      6'h0F: e = {7'h09, 7'h09};
      6'h10: e = {7'h71, 7'h51};
      6'h11: e = {7'h77, 7'h57};
      6'h12: e = {7'h65, 7'h45};
      6'h13: e = {7'h72, 7'h52};
      6'h14: e = {7'h74, 7'h54};
      6'h15: e = {7'h79, 7'h59};
      6'h16: e = {7'h75, 7'h55};
      6'h17: e = {7'h69, 7'h49};
      6'h18: e = {7'h6F, 7'h4F};
      6'h19: e = {7'h70, 7'h50};
      6'h1A: e = {7'h5B, 7'h7B};
      6'h1B: e = {7'h5D, 7'h7D};
      6'h1C: e = {7'h0A, 7'h0A};
      6'h1E: e = {7'h61, 7'h41};
      6'h1F: e = {7'h73, 7'h53};
      6'h20: e = {7'h64, 7'h44};
      6'h21: e = {7'h66, 7'h46};
      6'h22: e = {7'h67, 7'h47};
      6'h23: e = {7'h68, 7'h48};
      6'h24: e = {7'h6A, 7'h4A};
      6'h25: e = {7'h6B, 7'h4B};
      6'h26: e = {7'h6C, 7'h4C};
      6'h27: e = {7'h3B, 7'h3A};
      6'h28: e = {7'h27, 7'h22};
      6'h29: e = {7'h60, 7'h7E};
      6'h2B: e = {7'h5C, 7'h7C};
      6'h2C: e = {7'h7A, 7'h5A};
      6'h2D: e = {7'h78, 7'h58};
      6'h2E: e = {7'h63, 7'h43};
      6'h2F: e = {7'h76, 7'h56};
      6'h30: e = {7'h62, 7'h42};
      6'h31: e = {7'h6E, 7'h4E};
      6'h32: e = {7'h6D, 7'h4D};
      6'h33: e = {7'h2C, 7'h3C};
      6'h34: e = {7'h2E, 7'h3E};
      6'h35: e = {7'h2F, 7'h3F};
      6'h37: e = {7'h2A, 7'h2A};
      6'h39: e = {7'h20, 7'h20};
      default: e = 14'h0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== src/sc1a_in_if.sv =====
// input channel: one scan code byte per item
// no dependencies
`default_nettype none

interface sc1a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

// ===== src/sc1a_out_if.sv =====
// result channel: decoded character and modifier flags
// no dependencies
`default_nettype none

interface sc1a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       shift_flag;
  logic       ctrl_flag;
  logic       alt_flag;

  modport source (output valid, output ascii_char, output shift_flag,
                  output ctrl_flag, output alt_flag, input ready);
  modport sink   (input valid, input ascii_char, input shift_flag,
                  input ctrl_flag, input alt_flag, output ready);
endinterface

`default_nettype wire

// ===== src/sc1a_decode.sv =====
// combinational decode of one scan code against the current keyboard state
// depends on sc1a_pkg
`default_nettype none

module sc1a_decode (
  input  wire  sc1a_pkg::code_t      code,
  input  wire  sc1a_pkg::kbd_state_t cur,
  output sc1a_pkg::kbd_state_t       nxt,
  output sc1a_pkg::dec_result_t      res
);
  import sc1a_pkg::*;

  logic [6:0]  key;
  logic [13:0] entry;
  char_t       ch;
  logic        is_ctrl;
  logic        is_alt;
  logic        is_shift;
  logic        in_table;

  assign key      = code[6:0];
  assign entry    = key_entry(key[5:0]);
  assign ch       = cur.shift ? entry[6:0] : entry[13:7];
  assign is_ctrl  = (key == KEY_LCTRL);
  assign is_alt   = (key == KEY_LALT);
  assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
  assign in_table = cur.ext ? (is_ctrl || is_alt)
                            : ((key != 7'h00) && (key < KEY_LIMIT));

  always_comb begin
    nxt      = cur;
    nxt.ext  = 1'b0;
    res.emit = 1'b0;
    res.ch   = ch;
    if (code == PREFIX_CODE) begin
      nxt.ext = 1'b1;
    end else if (code[7]) begin
      if (is_ctrl) nxt.ctrl = 1'b0;
      if (is_alt) nxt.alt = 1'b0;
      if (!cur.ext && is_shift) nxt.shift = 1'b0;
    end else if (in_table) begin
      if (ch != 7'h00) begin
        res.emit = 1'b1;
      end else if (is_ctrl) begin
        nxt.ctrl = 1'b1;
      end else if (is_shift) begin
        nxt.shift = 1'b1;
      end else if (is_alt) begin
        nxt.alt = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/scancode_set1_to_ascii.sv =====
// top level: input register, decode stage and result register
// depends on sc1a_pkg, sc1a_in_if, sc1a_out_if and sc1a_decode
`default_nettype none

// Scan code set 1 to ASCII decoder. Each item is one raw keyboard byte; an
// 0xE0 prefix byte qualifies the byte after it. A byte is registered on
// acceptance, decoded from the input register against the prefix and
// Shift/Ctrl/Alt state, and a character, if any, lands in the result register
// with the modifier flags as they stood. One byte is accepted every cycle
// unless a character stalls before a full, untaken result register; a result
// passes the input and result registers. Bytes that give no result leave the
// pipeline even while a result waits to be taken. Caps Lock is not tracked.
module scancode_set1_to_ascii (
  input wire clk,
  input wire rst_n,
  sc1a_in_if.sink    in_ch,
  sc1a_out_if.source out_ch
);
  import sc1a_pkg::*;

  logic        s1_valid_r;
  code_t       s1_code_r;
  kbd_state_t  state_r;
  kbd_state_t  state_nxt;
  dec_result_t dec_res;
  logic        out_valid_r;
  char_t       out_char_r;
  logic        out_shift_r;
  logic        out_ctrl_r;
  logic        out_alt_r;
  logic        s1_move;

  sc1a_decode u_decode (
    .code (s1_code_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (dec_res)
  );

  assign s1_move     = s1_valid_r && (!dec_res.emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_move) state_r <= state_nxt;
      if (s1_move && dec_res.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) s1_code_r <= in_ch.scan_code;
    if (s1_move && dec_res.emit) begin
      out_char_r  <= dec_res.ch;
      out_shift_r <= state_r.shift;
      out_ctrl_r  <= state_r.ctrl;
      out_alt_r   <= state_r.alt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.shift_flag = out_shift_r;
  assign out_ch.ctrl_flag  = out_ctrl_r;
  assign out_ch.alt_flag   = out_alt_r;

`ifndef SYNTH
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r != 7'h00))
    else $error("result item with zero character");

  a_prefix_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_code_r == PREFIX_CODE)) |=> state_r.ext)
    else $error("prefix byte did not arm extended flag");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && dec_res.emit) |=> out_valid_r)
    else $error("decoded character lost");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with empty stage");
`endif

endmodule

`default_nettype wire

// ===== test/tb_scancode_set1_to_ascii.sv =====
// testbench for scancode_set1_to_ascii: directed and random scan code streams with
// random gaps and stalls on both channels, checked against an in-bench key decoder
// depends on sc1a_pkg, sc1a_in_if, sc1a_out_if and the scancode_set1_to_ascii rtl
module tb_scancode_set1_to_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import sc1a_pkg::*;

  localparam int         ITEM_TARGET  = 650;
  localparam int         RESET_CYCLES = 9;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 40000;
  localparam int         IDLE_PCT     = 18;
  localparam int         HOLD_START   = 150;
  localparam int         HOLD_CYCLES  = 60;
  localparam logic [6:0] KEY_CAPS     = 7'h3A;
  localparam logic       MAKE         = 1'b0;
  localparam logic       BREAK        = 1'b1;

  typedef struct packed {
    char_t ch;
    logic  shift;
    logic  ctrl;
    logic  alt;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n;

  sc1a_in_if  in_ch ();
  sc1a_out_if out_ch ();

  scancode_set1_to_ascii DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_t      scan_queue[$];
  key_event_t expected_chars[$];
  kbd_state_t kbd;
  int         sent_count;
  int         recv_cycles;
  int         hold_left;
  int         cycle_count = 0;
  int         mismatch_count = 0;

  always #10 clk = ~clk;

  // {unshifted, shifted}
  function automatic logic [15:0] key_glyphs(input logic [6:0] key);
    logic [15:0] g;
    case (key)
      7'h01: g = 16'h1B1B;
      7'h02: g = "1!";
      7'h03: g = "2@";
      7'h04: g = "3#";
      7'h05: g = "4$";
      7'h06: g = "5%";
      7'h07: g = "6^";
      7'h08: g = "7&";
      7'h09: g = "8*";
      7'h0A: g = "9(";
      7'h0B: g = "0)";
      7'h0C: g = "-_";
      7'h0D: g = "=+";
      7'h0E: g = 16'h0808;
      7'h0F: g = 16'h0909;
      7'h10: g = "qQ";
      7'h11: g = "wW";
      7'h12: g = "eE";
      7'h13: g = "rR";
      7'h14: g = "tT";
      7'h15: g = "yY";
      7'h16: g = "uU";
      7'h17: g = "iI";
      7'h18: g = "oO";
      7'h19: g = "pP";
      7'h1A: g = "[{";
      7'h1B: g = "]}";
      7'h1C: g = 16'h0A0A;
      7'h1E: g = "aA";
      7'h1F: g = "sS";
      7'h20: g = "dD";
      7'h21: g = "fF";
      7'h22: g = "gG";
      7'h23: g = "hH";
      7'h24: g = "jJ";
      7'h25: g = "kK";
      7'h26: g = "lL";
      7'h27: g = ";:";
      7'h28: g = "'\"";
      7'h29: g = "`~";
      7'h2B: g = "\\|";
      7'h2C: g = "zZ";
      7'h2D: g = "xX";
      7'h2E: g = "cC";
      7'h2F: g = "vV";
      7'h30: g = "bB";
      7'h31: g = "nN";
      7'h32: g = "mM";
      7'h33: g = ",<";
      7'h34: g = ".>";
      7'h35: g = "/?";
      7'h37: g = "**";
      7'h39: g = "  ";
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

  function automatic void decode_scan(input code_t code);
    logic        was_ext;
    logic [6:0]  key;
    logic [15:0] g;
    char_t       ch;
    if (code == PREFIX_CODE) begin
      kbd.ext = 1'b1;
      return;
    end
    was_ext = kbd.ext;
    kbd.ext = 1'b0;
    key     = code[6:0];
    if (code[7]) begin
      if (key == KEY_LCTRL) kbd.ctrl = 1'b0;
      if (key == KEY_LALT) kbd.alt = 1'b0;
      if (!was_ext && (key == KEY_LSHIFT || key == KEY_RSHIFT)) kbd.shift = 1'b0;
      return;
    end
    if (was_ext) begin
      if (key != KEY_LCTRL && key != KEY_LALT) return;
    end else if (key == 7'h00 || key >= KEY_LIMIT) begin
      return;
    end
    g  = key_glyphs(key);
    ch = kbd.shift ? g[6:0] : g[14:8];
    if (ch != 7'h00) begin
      expected_chars.push_back('{ch, kbd.shift, kbd.ctrl, kbd.alt});
    end else if (key == KEY_LCTRL) begin
      kbd.ctrl = 1'b1;
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      kbd.shift = 1'b1;
    end else if (key == KEY_LALT) begin
      kbd.alt = 1'b1;
    end
  endfunction

  task automatic push_key(input logic brk, input logic ext, input logic [6:0] key);
    if (ext) scan_queue.push_back(PREFIX_CODE);
    scan_queue.push_back({brk, key});
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.scan_code <= '0;
      kbd             = '0;
      sent_count      = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_scan(in_ch.scan_code);
        sent_count = sent_count + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (scan_queue.size() != 0 &&
            ((sent_count >= 300 && sent_count < 420) || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid     <= 1'b1;
          in_ch.scan_code <= scan_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    key_event_t exp_ev;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_cycles  = 0;
      hold_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected item: ascii_char %h", out_ch.ascii_char);
          mismatch_count++;
        end else begin
          exp_ev = expected_chars.pop_front();
          if (out_ch.ascii_char !== exp_ev.ch) begin
            $error("ascii_char expected %h got %h", exp_ev.ch, out_ch.ascii_char);
            mismatch_count++;
          end
          if (out_ch.shift_flag !== exp_ev.shift) begin
            $error("shift_flag expected %b got %b", exp_ev.shift, out_ch.shift_flag);
            mismatch_count++;
          end
          if (out_ch.ctrl_flag !== exp_ev.ctrl) begin
            $error("ctrl_flag expected %b got %b", exp_ev.ctrl, out_ch.ctrl_flag);
            mismatch_count++;
          end
          if (out_ch.alt_flag !== exp_ev.alt) begin
            $error("alt_flag expected %b got %b", exp_ev.alt, out_ch.alt_flag);
            mismatch_count++;
          end
        end
      end
      recv_cycles = recv_cycles + 1;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end else if (recv_cycles == HOLD_START) begin
        hold_left = HOLD_CYCLES;
      end
      out_ch.ready <= (hold_left == 0) &&
                      ((recv_cycles >= 400 && recv_cycles < 600) ||
                       $urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    rst_n = 1'b0;

    // directed: null code, escape, caps lock, range edges, break of key zero
    scan_queue.push_back(8'h00);
    push_key(MAKE, 1'b0, 7'h01);
    push_key(MAKE, 1'b0, KEY_CAPS);
    push_key(MAKE, 1'b0, KEY_LIMIT);
    scan_queue.push_back(8'h7F);
    scan_queue.push_back(8'hFF);
    scan_queue.push_back(8'h80);
    // repeated prefix then right ctrl, ctrl held over a letter, right ctrl release
    scan_queue.push_back(PREFIX_CODE);
    push_key(MAKE, 1'b1, KEY_LCTRL);
    push_key(MAKE, 1'b0, 7'h1E);
    push_key(BREAK, 1'b1, KEY_LCTRL);
    // shift, extended shift break is ignored, real release
    push_key(MAKE, 1'b0, KEY_LSHIFT);
    push_key(MAKE, 1'b0, 7'h02);
    push_key(BREAK, 1'b1, KEY_LSHIFT);
    push_key(MAKE, 1'b0, 7'h10);
    push_key(BREAK, 1'b0, KEY_LSHIFT);
    // right alt, space, left alt break, ignored extended make
    push_key(MAKE, 1'b1, KEY_LALT);
    push_key(MAKE, 1'b0, 7'h39);
    push_key(BREAK, 1'b0, KEY_LALT);
    push_key(MAKE, 1'b1, 7'h10);

    while (scan_queue.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        pick = $urandom_range(8'h01, KEY_CAPS);
        push_key(MAKE, 1'b0, pick[6:0]);
        if ($urandom_range(1)) push_key(BREAK, 1'b0, pick[6:0]);
      end else if (pick < 75) begin
        case ($urandom_range(5))
          0: push_key(pick >= 60, 1'b0, KEY_LSHIFT);
          1: push_key(pick >= 60, 1'b0, KEY_RSHIFT);
          2: push_key(pick >= 60, 1'b0, KEY_LCTRL);
          3: push_key(pick >= 60, 1'b0, KEY_LALT);
          4: push_key(pick >= 60, 1'b1, KEY_LCTRL);
          default: push_key(pick >= 60, 1'b1, KEY_LALT);
        endcase
      end else if (pick < 85) begin
        scan_queue.push_back(PREFIX_CODE);
        scan_queue.push_back(8'($urandom_range(255)));
      end else begin
        scan_queue.push_back(8'($urandom_range(255)));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (scan_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $error("%0d expected items never arrived", expected_chars.size());
    end
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sc1a_pkg.sv
src/sc1a_in_if.sv
src/sc1a_out_if.sv
src/sc1a_decode.sv
src/scancode_set1_to_ascii.sv
test/tb_scancode_set1_to_ascii.sv
